[rtl/skr_pkg.sv]
package skr_pkg;

    localparam int BYTE_W     = 8;
    localparam int LEN_W      = 4;
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 64;

    // Configuration register indexes.
    localparam logic [CFG_IDX_W-1:0] REG_KEY_BYTES    = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_KEY_LENGTH   = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_VALUE_BYTES  = 2'd2;
    localparam logic [CFG_IDX_W-1:0] REG_VALUE_LENGTH = 2'd3;

    // Bit positions inside the result tuser.
    localparam int TUSER_BYTE_VALID = 0;
    localparam int TUSER_STREAM_END = 1;
    localparam int TUSER_W          = 2;

    // Per-cell control of the window row.
    typedef struct packed {
        logic take;    // an item is accepted this cycle
        logic load;    // this cell receives the incoming byte
        logic shift;   // window moves one place toward cell 0
        logic active;  // cell lies inside the key length
    } skr_cell_ctl_t;

endpackage

[rtl/skr_cell.sv]
module skr_cell import skr_pkg::*; (
    input  logic                aclk,
    input  skr_cell_ctl_t       ctl,
    input  logic [BYTE_W-1:0]   in_byte,
    input  logic [BYTE_W-1:0]   key_byte,
    input  logic [BYTE_W-1:0]   nbr_cur,
    input  logic                match_in,
    output logic [BYTE_W-1:0]   cur,
    output logic                match_out
);

    logic [BYTE_W-1:0] byte_reg;
    logic [BYTE_W-1:0] byte_next;

    // The cell's view of the window with the new byte already in place.
    assign cur       = ctl.load ? in_byte : byte_reg;
    assign match_out = match_in & (~ctl.active | (cur == key_byte));
    assign byte_next = ctl.shift ? nbr_cur : cur;

    always_ff @(posedge aclk) begin
        if (ctl.take) begin
            byte_reg <= byte_next;
        end
    end

endmodule

[rtl/skr_emit.sv]
module skr_emit import skr_pkg::*; #(
    parameter int DEPTH = 8
) (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          take,
    input  logic [DEPTH-1:0][BYTE_W-1:0]  batch_bytes,
    input  logic [LEN_W-1:0]              batch_n,
    input  logic                          batch_end,
    output logic                          can_take,
    output logic                          m_tvalid,
    input  logic                          m_tready,
    output logic [BYTE_W-1:0]             m_tdata,
    output logic                          m_tlast,
    output logic [TUSER_W-1:0]            m_tuser
);

    localparam int RW = $clog2(DEPTH + 1);

    logic [DEPTH-1:0][BYTE_W-1:0] buf_reg;
    logic [DEPTH-1:0][BYTE_W-1:0] buf_next;
    logic [RW-1:0]                rem_reg;
    logic [RW-1:0]                rem_next;
    logic                         marker_reg;
    logic                         marker_next;
    logic                         end_reg;
    logic                         end_next;
    logic                         last_out;
    logic                         pop;

    assign last_out = (rem_reg == RW'(1));
    assign pop      = m_tvalid & m_tready;
    assign can_take = (rem_reg == '0) | (m_tready & last_out);

    assign m_tvalid = (rem_reg != '0);
    assign m_tdata  = marker_reg ? '0 : buf_reg[0];
    assign m_tlast  = last_out;
    assign m_tuser[TUSER_BYTE_VALID] = ~marker_reg;
    assign m_tuser[TUSER_STREAM_END] = last_out & end_reg;

    always_comb begin
        buf_next    = buf_reg;
        rem_next    = rem_reg;
        marker_next = marker_reg;
        end_next    = end_reg;
        if (take) begin
            buf_next    = batch_bytes;
            end_next    = batch_end;
            marker_next = (batch_n == '0);
            if (batch_n != '0) begin
                rem_next = RW'(batch_n);
            end else if (batch_end) begin
                rem_next = RW'(1);
            end else begin
                rem_next = '0;
            end
        end else if (pop) begin
            for (int i = 0; i < DEPTH - 1; i++) begin
                buf_next[i] = buf_reg[i+1];
            end
            buf_next[DEPTH-1] = '0;
            rem_next = rem_reg - RW'(1);
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            rem_reg <= '0;
        end else begin
            rem_reg <= rem_next;
        end
    end

    always_ff @(posedge aclk) begin
        buf_reg    <= buf_next;
        marker_reg <= marker_next;
        end_reg    <= end_next;
    end

endmodule

[rtl/stream_key_replace.sv]
// Byte-stream find and replace. Every non-overlapping, leftmost-first
// occurrence of the configured key (1 to MAX_KEY_BYTES bytes) is replaced by
// the configured value (0 to MAX_VALUE_BYTES bytes); every other byte passes
// through in order. Bytes that could still start a match wait in a window of
// at most key_length-1 bytes, so output lags input by that many bytes until a
// byte with tlast set ends the stream and flushes the window. Each accepted
// input item yields a run of result items that ends with tlast; an item that
// completes nothing yields no result, except that an end item with nothing to
// emit yields one empty result with tuser byte_valid low. The block takes one
// input item per cycle while runs are at most one byte and m_tready is high; a
// longer run holds off the next item while the output buffer drains it a
// byte per cycle that m_tready is high, and the next item is taken as its
// last byte leaves. Configuration writes are always accepted and must be
// made while the block is idle; writing key_length discards the window bytes.
module stream_key_replace import skr_pkg::*; #(
    parameter int MAX_KEY_BYTES   = 8,
    parameter int MAX_VALUE_BYTES = 8
) (
    input  logic                   aclk,
    input  logic                   aresetn,
    // Input stream. s_tdata: in_byte. s_tlast: in_end.
    input  logic                   s_tvalid,
    output logic                   s_tready,
    input  logic [BYTE_W-1:0]      s_tdata,
    input  logic                   s_tlast,
    // Result stream. m_tdata: out_byte. m_tlast: run_last.
    output logic                   m_tvalid,
    input  logic                   m_tready,
    output logic [BYTE_W-1:0]      m_tdata,
    output logic                   m_tlast,
    // m_tuser bits from low up: byte_valid, stream_end.
    output logic [TUSER_W-1:0]     m_tuser,
    // Configuration write channel.
    input  logic                   cfg_valid,
    output logic                   cfg_ready,
    input  logic [CFG_IDX_W-1:0]   cfg_index,
    input  logic [CFG_DATA_W-1:0]  cfg_data
);

    localparam int BUF_DEPTH = (MAX_KEY_BYTES > MAX_VALUE_BYTES) ?
                               MAX_KEY_BYTES : MAX_VALUE_BYTES;

    // Configuration registers.
    logic [MAX_KEY_BYTES-1:0][BYTE_W-1:0]   key_reg;
    logic [LEN_W-1:0]                       key_len_reg;
    logic [MAX_VALUE_BYTES-1:0][BYTE_W-1:0] value_reg;
    logic [LEN_W-1:0]                       value_len_reg;

    // Window fill level.
    logic [LEN_W-1:0] count_reg;
    logic [LEN_W-1:0] count_next;

    logic [LEN_W-1:0] klen;
    logic [LEN_W-1:0] vlen;
    logic [LEN_W-1:0] count_inc;
    logic             accept;
    logic             cfg_fire;
    logic             full;
    logic             match;
    logic             can_take;

    skr_cell_ctl_t [MAX_KEY_BYTES-1:0]      cell_ctl;
    logic [MAX_KEY_BYTES-1:0][BYTE_W-1:0]   cell_cur;
    logic [MAX_KEY_BYTES:0]                 match_chain;

    logic [BUF_DEPTH-1:0][BYTE_W-1:0]       batch_bytes;
    logic [LEN_W-1:0]                       batch_n;

    assign cfg_ready = 1'b1;
    assign cfg_fire  = cfg_valid & cfg_ready;
    assign s_tready  = can_take;
    assign accept    = s_tvalid & s_tready;

    // Out-of-range lengths are clamped: a key of zero bytes acts as one.
    always_comb begin
        klen = key_len_reg;
        if (klen == '0) begin
            klen = LEN_W'(1);
        end else if (klen > LEN_W'(MAX_KEY_BYTES)) begin
            klen = LEN_W'(MAX_KEY_BYTES);
        end
        vlen = value_len_reg;
        if (vlen > LEN_W'(MAX_VALUE_BYTES)) begin
            vlen = LEN_W'(MAX_VALUE_BYTES);
        end
    end

    // The window is full once the new byte brings it to the key length; only
    // then is the match from the cell row meaningful.
    assign count_inc = count_reg + LEN_W'(1);
    assign full      = (count_inc == klen);
    assign match     = full & match_chain[MAX_KEY_BYTES];

    // Window row: each cell holds one byte, compares it against its key byte
    // and passes its byte to the left neighbor when the oldest byte leaves.
    assign match_chain[0] = 1'b1;

    for (genvar i = 0; i < MAX_KEY_BYTES; i++) begin : g_cell
        logic [BYTE_W-1:0] nbr;

        if (i == MAX_KEY_BYTES - 1) begin : g_end
            assign nbr = '0;
        end else begin : g_mid
            assign nbr = cell_cur[i+1];
        end

        assign cell_ctl[i].take   = accept;
        assign cell_ctl[i].load   = (count_reg == LEN_W'(i));
        assign cell_ctl[i].shift  = full & ~match & ~s_tlast;
        assign cell_ctl[i].active = (LEN_W'(i) < klen);

        skr_cell u_cell (
            .aclk      (aclk),
            .ctl       (cell_ctl[i]),
            .in_byte   (s_tdata),
            .key_byte  (key_reg[i]),
            .nbr_cur   (nbr),
            .match_in  (match_chain[i]),
            .cur       (cell_cur[i]),
            .match_out (match_chain[i+1])
        );
    end

    // Results of one item: the value bytes on a match, otherwise the leading
    // window bytes. Without an end only the oldest byte of a full window
    // leaves; with an end the whole window goes out.
    always_comb begin
        for (int i = 0; i < BUF_DEPTH; i++) begin
            batch_bytes[i] = '0;
            if (match) begin
                if (i < MAX_VALUE_BYTES) begin
                    batch_bytes[i] = value_reg[i];
                end
            end else if (i < MAX_KEY_BYTES) begin
                batch_bytes[i] = cell_cur[i];
            end
        end
        if (match) begin
            batch_n = vlen;
        end else if (s_tlast) begin
            batch_n = count_inc;
        end else if (full) begin
            batch_n = LEN_W'(1);
        end else begin
            batch_n = '0;
        end
    end

    always_comb begin
        count_next = count_reg;
        if (cfg_fire && cfg_index == REG_KEY_LENGTH) begin
            count_next = '0;
        end else if (accept) begin
            if (match || s_tlast) begin
                count_next = '0;
            end else if (full) begin
                count_next = klen - LEN_W'(1);
            end else begin
                count_next = count_inc;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            key_reg       <= '0;
            key_len_reg   <= LEN_W'(1);
            value_reg     <= '0;
            value_len_reg <= '0;
            count_reg     <= '0;
        end else begin
            count_reg <= count_next;
            if (cfg_fire) begin
                case (cfg_index)
                    REG_KEY_BYTES: begin
                        key_reg <= cfg_data[MAX_KEY_BYTES*BYTE_W-1:0];
                    end
                    REG_KEY_LENGTH: begin
                        key_len_reg <= cfg_data[LEN_W-1:0];
                    end
                    REG_VALUE_BYTES: begin
                        value_reg <= cfg_data[MAX_VALUE_BYTES*BYTE_W-1:0];
                    end
                    REG_VALUE_LENGTH: begin
                        value_len_reg <= cfg_data[LEN_W-1:0];
                    end
                    default: begin
                    end
                endcase
            end
        end
    end

    // Output buffer: holds the result run of one item and drains it a byte
    // per cycle while m_tready is high.
    skr_emit #(
        .DEPTH (BUF_DEPTH)
    ) u_emit (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .take        (accept),
        .batch_bytes (batch_bytes),
        .batch_n     (batch_n),
        .batch_end   (s_tlast),
        .can_take    (can_take),
        .m_tvalid    (m_tvalid),
        .m_tready    (m_tready),
        .m_tdata     (m_tdata),
        .m_tlast     (m_tlast),
        .m_tuser     (m_tuser)
    );

endmodule
